>>> src/scr_pkg.sv
// Shared types and constants for the serial chunk receiver.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package scr_pkg;

    // Field and counter widths
    localparam int CNT_W     = 20;
    localparam int LEN_W     = 5;
    localparam int BYTE_W    = 8;
    localparam int BIT_IDX_W = 3;
    localparam int CFG_IDX_W = 2;

    // Result queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // floor(d / 3) = (d * THIRD_MUL) >> THIRD_SHIFT, exact for d below 2**21
    localparam int                 THIRD_SHIFT = 22;
    localparam logic [CNT_W:0]     THIRD_MUL   = 21'd1398102;
    localparam int                 PROD_W      = 2 * CNT_W + 1;

    // Register reset values
    localparam logic [CNT_W-1:0] BIT_PERIOD_RST   = 20'd33333;
    localparam logic             CHUNK_MODE_RST   = 1'b1;
    localparam logic             ACTIVE_LEVEL_RST = 1'b0;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_START_A = 3'd1,
        PH_START_B = 3'd2,
        PH_LEN     = 3'd3,
        PH_BYTE    = 3'd4,
        PH_STOP_A  = 3'd5,
        PH_STOP_B  = 3'd6
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIT_PERIOD   = 2'd0,
        REG_CHUNK_MODE   = 2'd1,
        REG_ACTIVE_LEVEL = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [CNT_W-1:0] bit_period;
        logic             chunk_mode;
        logic             active_level;
    } t_cfg;

    typedef struct packed {
        logic              last_in_frame;
        logic [LEN_W-1:0]  frame_length;
        logic [BYTE_W-1:0] data_byte;
    } t_result;

endpackage

>>> src/scr_front.sv
// Front end: line sampler and frame state machine, one tick per accepted beat.
// Depends on scr_pkg.
`timescale 1ns / 1ps

module scr_front import scr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_tick,        // a line sample beat is taken this cycle
    input  logic    i_line,
    input  t_cfg    i_cfg,
    output logic    o_res_valid,
    output t_result o_res
);

    t_phase               r_phase, n_phase;
    logic [CNT_W-1:0]     r_tick, n_tick;
    logic [BIT_IDX_W-1:0] r_bit_idx, n_bit_idx;
    logic [BYTE_W-1:0]    r_shift, n_shift;
    logic [LEN_W-1:0]     r_len, n_len;
    logic [LEN_W-1:0]     r_left, n_left;
    logic [CNT_W-1:0]     r_third, r_half;

    logic [CNT_W-1:0]     d_eff;
    logic [PROD_W-1:0]    third_prod;
    logic [CNT_W-1:0]     tick_inc;
    logic                 bit_val;
    logic                 hit_period, hit_third, hit_half;
    logic                 third_zero, half_zero;
    logic                 is_start, seg_end, do_sample, samp_len;
    logic [BIT_IDX_W-1:0] idx;
    logic [LEN_W-1:0]     len_new, left_dec;
    logic [BYTE_W-1:0]    shift_new;
    logic                 len_last, byte_last;
    t_phase               samp_phase;

    // Effective period and its third and half, registered off the config
    assign d_eff      = (i_cfg.bit_period == '0) ? CNT_W'(1) : i_cfg.bit_period;
    assign third_prod = PROD_W'(d_eff) * PROD_W'(THIRD_MUL);

    always_ff @(posedge i_clk) begin
        r_third <= CNT_W'(third_prod[PROD_W-1:THIRD_SHIFT]);
        r_half  <= d_eff >> 1;
    end

    // Segment timing, counter saturates at full scale
    assign tick_inc   = (r_tick == '1) ? r_tick : r_tick + CNT_W'(1);
    assign hit_period = (tick_inc >= d_eff);
    assign hit_third  = (tick_inc >= r_third);
    assign hit_half   = (tick_inc >= r_half);
    assign third_zero = (r_third == '0);
    assign half_zero  = (r_half == '0);
    assign bit_val    = (i_line == i_cfg.active_level);

    always_comb begin
        seg_end = 1'b0;
        case (r_phase) inside
            PH_START_A, PH_LEN, PH_BYTE, PH_STOP_A: seg_end = hit_period;
            PH_START_B: seg_end = hit_third;
            PH_STOP_B:  seg_end = hit_half;
            default:    seg_end = 1'b0;
        endcase
    end

    // Sample decode; the first sample after the start wait picks length or byte
    assign is_start  = (r_phase == PH_START_A) || (r_phase == PH_START_B);
    assign do_sample = ((r_phase == PH_START_A) && hit_period && third_zero) ||
                       ((r_phase == PH_START_B) && hit_third) ||
                       (((r_phase == PH_LEN) || (r_phase == PH_BYTE)) && hit_period);
    assign samp_len  = is_start ? (r_left == '0) : (r_phase == PH_LEN);
    assign idx       = is_start ? '0 : r_bit_idx;
    assign len_new   = r_len | (LEN_W'(bit_val) << idx);
    assign shift_new = r_shift | (BYTE_W'(bit_val) << idx);
    assign len_last  = (32'(idx) >= LEN_W - 1);
    assign byte_last = (idx == '1);
    assign left_dec  = r_left - LEN_W'(1);

    always_comb begin
        if (samp_len) begin
            if (!len_last)
                samp_phase = PH_LEN;
            else if (len_new == '0)
                samp_phase = PH_STOP_A;
            else
                samp_phase = PH_BYTE;
        end else begin
            if (byte_last && (left_dec == '0))
                samp_phase = PH_STOP_A;
            else
                samp_phase = PH_BYTE;
        end
    end

    // Next state
    always_comb begin
        n_phase = r_phase;
        if (i_tick) begin
            unique case (r_phase) inside
                PH_IDLE: begin
                    if (bit_val) n_phase = PH_START_A;
                end
                PH_START_A: begin
                    if (hit_period) n_phase = third_zero ? samp_phase : PH_START_B;
                end
                PH_START_B: begin
                    if (hit_third) n_phase = samp_phase;
                end
                PH_LEN, PH_BYTE: begin
                    if (hit_period) n_phase = samp_phase;
                end
                PH_STOP_A: begin
                    if (hit_period) n_phase = half_zero ? PH_IDLE : PH_STOP_B;
                end
                PH_STOP_B: begin
                    if (hit_half) n_phase = PH_IDLE;
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    // Datapath and result outputs
    always_comb begin
        n_tick      = r_tick;
        n_bit_idx   = r_bit_idx;
        n_shift     = r_shift;
        n_len       = r_len;
        n_left      = r_left;
        o_res_valid = 1'b0;
        o_res.data_byte     = shift_new;
        o_res.frame_length  = r_len;
        o_res.last_in_frame = (r_left <= LEN_W'(1));
        if (i_tick) begin
            if (r_phase == PH_IDLE) begin
                if (bit_val) begin
                    n_tick    = '0;
                    n_bit_idx = '0;
                    n_shift   = '0;
                    n_len     = i_cfg.chunk_mode ? '0 : LEN_W'(1);
                    n_left    = i_cfg.chunk_mode ? '0 : LEN_W'(1);
                end
            end else begin
                n_tick = seg_end ? '0 : tick_inc;
                if (!seg_end && !is_start && (r_phase != PH_LEN) && (r_phase != PH_BYTE)
                    && (r_phase != PH_STOP_A) && (r_phase != PH_STOP_B))
                    n_tick = '0;
                if (do_sample) begin
                    if (samp_len) begin
                        n_len = len_new;
                        if (len_last) begin
                            n_bit_idx = '0;
                            n_shift   = '0;
                            if (len_new != '0) n_left = len_new;
                        end else begin
                            n_bit_idx = idx + BIT_IDX_W'(1);
                        end
                    end else if (byte_last) begin
                        o_res_valid = 1'b1;
                        n_left      = left_dec;
                        n_bit_idx   = '0;
                        n_shift     = '0;
                    end else begin
                        n_shift   = shift_new;
                        n_bit_idx = idx + BIT_IDX_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_tick    <= '0;
            r_bit_idx <= '0;
            r_shift   <= '0;
            r_len     <= '0;
            r_left    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_tick    <= n_tick;
            r_bit_idx <= n_bit_idx;
            r_shift   <= n_shift;
            r_len     <= n_len;
            r_left    <= n_left;
        end
    end

endmodule

>>> src/scr_queue.sv
// Small result queue between the frame front end and the output stage.
// Depends on scr_pkg.
`timescale 1ns / 1ps

module scr_queue import scr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_result            i_din,
    input  logic               i_pop,
    output t_result            o_dout,
    output logic               o_valid,
    output logic               o_full,
    output logic [Q_CNT_W-1:0] o_count
);

    t_result              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wptr, n_wptr;
    logic [Q_PTR_W-1:0]   r_rptr, n_rptr;
    logic [Q_CNT_W-1:0]   r_count, n_count;
    logic                 do_push, do_pop;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and fill bookkeeping
    always_comb begin
        n_wptr  = do_push ? r_wptr + Q_PTR_W'(1) : r_wptr;
        n_rptr  = do_pop ? r_rptr + Q_PTR_W'(1) : r_rptr;
        n_count = r_count + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wptr] <= i_din;
    end

    assign o_dout  = r_mem[r_rptr];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_count = r_count;

endmodule

>>> src/scr_back.sv
// Back end: output register driving the master stream port.
// Depends on scr_pkg.
`timescale 1ns / 1ps

module scr_back import scr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_result i_q_data,
    output logic    o_q_pop,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_data
);

    logic    r_valid, n_valid;
    t_result r_data;

    // Load a new beat when the register is empty or being drained
    assign o_q_pop = i_q_valid && (!r_valid || i_ready);

    always_comb begin
        n_valid = r_valid;
        if (o_q_pop)
            n_valid = 1'b1;
        else if (i_ready)
            n_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else          r_valid <= n_valid;
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_data <= i_q_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> src/serial_chunk_receiver_core.sv
// Top level of the serial chunk receiver: config registers, front end, queue, output stage.
// Depends on scr_pkg, scr_front, scr_queue, scr_back.
//
//   port group  dir  payload
//   s_*         in   tdata[0] line_level, tdata[7:1] zero
//   m_*         out  tdata[7:0] data_byte, tdata[12:8] frame_length; tlast last_in_frame
//   i_cfg_*     in   index 0 bit_period, 1 chunk_mode, 2 active_level
//
// One line sample beat is taken every cycle in which s_tvalid and s_tready are both high;
// a received byte reaches m_tvalid through the queue, then the output register.
// s_tready falls only when the four-entry result queue is full, i.e. after
// m_tready has been held low across several bytes.
// Reset is synchronous and active low; config returns to its reset values.
`timescale 1ns / 1ps

module serial_chunk_receiver_core import scr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,      // [0] line_level
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,      // [7:0] data_byte, [12:8] frame_length
    output logic                 m_tlast,      // last_in_frame
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CNT_W-1:0]     i_cfg_data
);

    t_cfg               r_cfg;
    logic               tick;
    logic               res_valid;
    t_result            res;
    t_result            q_dout;
    logic               q_valid, q_full, q_pop;
    logic [Q_CNT_W-1:0] q_count;
    t_result            out_data;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_period   <= BIT_PERIOD_RST;
            r_cfg.chunk_mode   <= CHUNK_MODE_RST;
            r_cfg.active_level <= ACTIVE_LEVEL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BIT_PERIOD:   r_cfg.bit_period   <= i_cfg_data;
                REG_CHUNK_MODE:   r_cfg.chunk_mode   <= i_cfg_data[0];
                REG_ACTIVE_LEVEL: r_cfg.active_level <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign s_tready = !q_full;
    assign tick     = s_tvalid && s_tready;

    scr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (tick),
        .i_line      (s_tdata[0]),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    scr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_din   (res),
        .i_pop   (q_pop),
        .o_dout  (q_dout),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_count (q_count)
    );

    scr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_dout),
        .o_q_pop   (q_pop),
        .i_ready   (m_tready),
        .o_valid   (m_tvalid),
        .o_data    (out_data)
    );

    assign m_tdata = {3'b000, out_data.frame_length, out_data.data_byte};
    assign m_tlast = out_data.last_in_frame;

    // A finished byte must always find room in the queue
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !q_full)
        else $error("result produced while queue full");

    // Fill count stays within depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count out of range");

    // Output beat is presented in the cycle after a queue pop
    a_pop_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> m_tvalid)
        else $error("popped result not presented");

endmodule
